FILE: hdl/b64e_pkg.sv
// b64e_pkg: shared types, character constants and the sextet-to-ascii mapping
// used by the base64 stream encoder modules; depends on nothing

package b64e_pkg;

	localparam int CHAR_W   = 7;
	localparam int GROUP_N  = 4;
	localparam int SLOT_W   = $clog2(GROUP_N);

	localparam logic [CHAR_W-1:0] CHAR_PAD   = 7'h3D;
	localparam logic [CHAR_W-1:0] CHAR_PLUS  = 7'h2B;
	localparam logic [CHAR_W-1:0] CHAR_DASH  = 7'h2D;
	localparam logic [CHAR_W-1:0] CHAR_SLASH = 7'h2F;
	localparam logic [CHAR_W-1:0] CHAR_UC_A  = 7'h41;
	localparam logic [CHAR_W-1:0] CHAR_LC_Z  = 7'h7A;
	localparam logic [CHAR_W-1:0] CHAR_LC_A  = 7'h61;
	localparam logic [CHAR_W-1:0] CHAR_UC_Z  = 7'h5A;
	localparam logic [CHAR_W-1:0] CHAR_D0    = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_D9    = 7'h39;

	typedef enum logic [1:0] {
		PH_FIRST  = 2'd0,
		PH_SECOND = 2'd1,
		PH_THIRD  = 2'd2
	} phase_t;

	typedef struct packed {
		logic [GROUP_N-1:0][CHAR_W-1:0] chars;
		logic [SLOT_W-1:0]              last_slot;
		logic                           last;
	} group_t;

	function automatic logic [CHAR_W-1:0] sextet_char(input logic [5:0] idx,
		input logic url);
		logic [CHAR_W-1:0] wide;
		wide = {1'b0, idx};
		if (idx < 6'd26) begin
			sextet_char = CHAR_UC_A + wide;
		end else if (idx < 6'd52) begin
			sextet_char = wide + 7'd71;
		end else if (idx < 6'd62) begin
			sextet_char = wide - 7'd4;
		end else if (idx == 6'd62) begin
			sextet_char = url ? CHAR_DASH : CHAR_PLUS;
		end else begin
			sextet_char = CHAR_SLASH;
		end
	endfunction

endpackage

FILE: hdl/b64e_encode.sv
// b64e_encode: group position and leftover bits, plus the combinational
// mapping of one input byte to its group of characters; uses b64e_pkg

module b64e_encode import b64e_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       url_alphabet,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic       advance,
	output group_t     grp
);

	phase_t     phase_q;
	phase_t     phase_d;
	logic [3:0] left_q;
	logic [3:0] left_d;

	always_comb begin
		grp.chars     = '{default: CHAR_PAD};
		grp.last_slot = '0;
		grp.last      = last_byte;
		phase_d       = PH_FIRST;
		left_d        = '0;
		unique case (phase_q)
			PH_SECOND: begin
				grp.chars[0] = sextet_char({left_q[1:0], data_byte[7:4]}, url_alphabet);
				if (last_byte) begin
					grp.chars[1]  = sextet_char({data_byte[3:0], 2'b00}, url_alphabet);
					grp.last_slot = SLOT_W'(2);
				end else begin
					phase_d = PH_THIRD;
					left_d  = data_byte[3:0];
				end
			end
			PH_THIRD: begin
				grp.chars[0]  = sextet_char({left_q, data_byte[7:6]}, url_alphabet);
				grp.chars[1]  = sextet_char(data_byte[5:0], url_alphabet);
				grp.last_slot = SLOT_W'(1);
			end
			default: begin
				grp.chars[0] = sextet_char(data_byte[7:2], url_alphabet);
				if (last_byte) begin
					grp.chars[1]  = sextet_char({data_byte[1:0], 4'b0000}, url_alphabet);
					grp.last_slot = SLOT_W'(3);
				end else begin
					phase_d = PH_SECOND;
					left_d  = {2'b00, data_byte[1:0]};
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			left_q  <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			left_q  <= left_d;
		end
	end

endmodule

FILE: hdl/b64e_serial.sv
// b64e_serial: result register for one character group and the slot counter
// that hands the characters out one per transfer; uses b64e_pkg

module b64e_serial import b64e_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  group_t            grp,
	output logic              free,
	output logic              valid,
	input  logic              ready,
	output logic [CHAR_W-1:0] out_char,
	output logic              last_char
);

	logic              valid_s2;
	group_t            grp_s2;
	logic [SLOT_W-1:0] slot_q;
	logic              fire;
	logic              drained;
	logic              at_end;

	assign at_end    = (slot_q == grp_s2.last_slot);
	assign fire      = valid_s2 && ready;
	assign drained   = fire && at_end;
	assign free      = !valid_s2 || drained;
	assign valid     = valid_s2;
	assign out_char  = grp_s2.chars[slot_q];
	assign last_char = grp_s2.last && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			slot_q   <= '0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			slot_q   <= '0;
		end else if (drained) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			slot_q <= slot_q + SLOT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			grp_s2 <= grp;
		end
	end

endmodule

FILE: hdl/base64_stream_encoder.sv
// base64 stream encoder: one byte per input transfer, one character per output transfer
// a byte is registered at input, then loaded into the result register once that is free
// throughput: up to one byte per cycle, bounded by the output at one character per cycle
// (4 characters per 3 bytes, so a steady byte stream is limited by the character output)
// reset: arst_n clears the group position, leftover bits, alphabet select and both stages
// uses b64e_pkg, b64e_encode and b64e_serial

module base64_stream_encoder import b64e_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,     // url_alphabet
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,    // [7:0] data_byte
	input  logic       s_axis_tlast,    // last_byte
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,    // [6:0] out_char, [7] zero
	output logic       m_axis_tlast     // last_char
);

	logic              url_q;
	logic              valid_s1;
	logic [7:0]        data_s1;
	logic              last_s1;
	logic              s2_free;
	logic              advance;
	group_t            grp;
	logic [CHAR_W-1:0] out_char;

	assign advance       = valid_s1 && s2_free;
	assign s_axis_tready = !valid_s1 || s2_free;
	assign m_axis_tdata  = {1'b0, out_char};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			url_q <= 1'b0;
		end else if (cfg_wr_en) begin
			url_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			data_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	b64e_encode u_encode (
		.clk          (clk),
		.arst_n       (arst_n),
		.url_alphabet (url_q),
		.data_byte    (data_s1),
		.last_byte    (last_s1),
		.advance      (advance),
		.grp          (grp)
	);

	b64e_serial u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.grp       (grp),
		.free      (s2_free),
		.valid     (m_axis_tvalid),
		.ready     (m_axis_tready),
		.out_char  (out_char),
		.last_char (m_axis_tlast)
	);

endmodule

FILE: hdl/b64e_check.sv
// b64e_check: port-level assertions for the base64 stream encoder, bound to the top
// uses b64e_pkg for the character constants

module b64e_check import b64e_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast
);

	logic [CHAR_W-1:0] ch;
	logic              legal;
	assign ch = m_axis_tdata[CHAR_W-1:0];
	assign legal = (ch >= CHAR_UC_A && ch <= CHAR_UC_Z) || (ch >= CHAR_LC_A && ch <= CHAR_LC_Z)
		|| (ch >= CHAR_D0 && ch <= CHAR_D9) || ch == CHAR_PLUS || ch == CHAR_DASH
		|| ch == CHAR_SLASH || ch == CHAR_PAD;

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !m_axis_tvalid)
		else $error("output valid during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tlast))
		else $error("stalled output changed");

	a_alphabet: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> legal && !m_axis_tdata[7])
		else $error("output is not a base64 character");

	a_pad_pair: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && ch == CHAR_PAD && !m_axis_tlast
		|=> m_axis_tvalid && m_axis_tdata[CHAR_W-1:0] == CHAR_PAD && m_axis_tlast)
		else $error("padding not followed by final padding");

	a_pad_only_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && ch == CHAR_PAD && m_axis_tlast
		|=> !(m_axis_tvalid && m_axis_tdata[CHAR_W-1:0] == CHAR_PAD))
		else $error("padding after final character");

endmodule

bind base64_stream_encoder b64e_check u_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

FILE: tb/testbench.sv
// testbench for base64_stream_encoder: byte transfers in, ascii character transfers out
// a directed table and random messages are checked against typed strings or an in-bench base64 predictor
// depends on b64e_pkg and the encoder rtl only
`timescale 1ns / 100ps

module testbench;
	import b64e_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int DIR_N = 25;

	typedef struct packed {
		logic [6:0] ch;
		logic       fin;
	} b64_char_t;

	typedef struct packed {
		logic        url;
		logic [7:0]  data;
		logic        last;
		logic [2:0]  n_typed;
		logic [31:0] text;
	} stim_row_t;

	// typed rows hold their characters as a string, first character leftmost
	localparam stim_row_t DIRECTED [DIR_N] = '{
		'{1'b0, 8'h00, 1'b1, 3'd4, "AA=="},
		'{1'b0, 8'hFF, 1'b1, 3'd4, "/w=="},
		'{1'b0, 8'h4D, 1'b0, 3'd1, "T"},
		'{1'b0, 8'h61, 1'b0, 3'd1, "W"},
		'{1'b0, 8'h6E, 1'b1, 3'd2, "Fu"},
		'{1'b0, 8'h4D, 1'b0, 3'd1, "T"},
		'{1'b0, 8'h61, 1'b1, 3'd3, "WE="},
		'{1'b0, 8'hF8, 1'b1, 3'd4, "+A=="},
		'{1'b0, 8'hFC, 1'b1, 3'd4, "/A=="},
		'{1'b1, 8'hF8, 1'b1, 3'd4, "-A=="},
		'{1'b1, 8'hFC, 1'b1, 3'd4, "/A=="},
		'{1'b1, 8'hFF, 1'b0, 3'd0, 32'h0},
		'{1'b1, 8'hFF, 1'b0, 3'd0, 32'h0},
		'{1'b1, 8'hFF, 1'b1, 3'd0, 32'h0},
		'{1'b1, 8'h03, 1'b0, 3'd0, 32'h0},
		'{1'b1, 8'hEF, 1'b0, 3'd0, 32'h0},
		'{1'b1, 8'hBE, 1'b0, 3'd0, 32'h0},
		'{1'b1, 8'hD3, 1'b0, 3'd0, 32'h0},
		'{1'b1, 8'h9F, 1'b0, 3'd0, 32'h0},
		'{1'b1, 8'h7F, 1'b1, 3'd0, 32'h0},
		'{1'b0, 8'h00, 1'b0, 3'd0, 32'h0},
		'{1'b0, 8'h00, 1'b0, 3'd0, 32'h0},
		'{1'b0, 8'h00, 1'b0, 3'd0, 32'h0},
		'{1'b0, 8'h80, 1'b1, 3'd0, 32'h0},
		'{1'b0, 8'h3F, 1'b1, 3'd0, 32'h0}
	};

	logic       clk;
	logic       arst_n = 1'b1;
	logic       cfg_wr_en = 1'b0;
	logic       cfg_wr_data = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic       s_axis_tlast = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;

	phase_t     enc_phase = PH_FIRST;
	logic [3:0] enc_carry = 4'h0;
	logic       alpha_url = 1'b0;

	b64_char_t  expected_chars [$];
	int         send_idle_pct = 0;
	int         stall_pct = 0;
	int         hold_left = 0;
	int         cycles = 0;
	int         mismatches = 0;
	int         bytes_sent = 0;
	int         messages = 0;
	int         chars_seen = 0;
	int         cfg_writes = 0;

	base64_stream_encoder u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb: timeout with %0d characters outstanding", expected_chars.size());
			$display("tb: failure");
			$finish;
		end
	end

	function automatic logic [6:0] sextet_ascii(input logic [5:0] idx);
		if (idx < 6'd26)
			return CHAR_UC_A + 7'(idx);
		if (idx < 6'd52)
			return CHAR_LC_A + 7'(idx - 6'd26);
		if (idx < 6'd62)
			return CHAR_D0 + 7'(idx - 6'd52);
		if (idx == 6'd62)
			return alpha_url ? CHAR_DASH : CHAR_PLUS;
		return CHAR_SLASH;
	endfunction

	// advances the encoder state by one byte and returns the characters it completes
	function automatic int encode_byte(input logic [7:0] b, input logic fin,
		output b64_char_t outs [4]);
		int n;
		n = 0;
		case (enc_phase)
		PH_SECOND: begin
			outs[0] = '{sextet_ascii({enc_carry[1:0], b[7:4]}), 1'b0};
			if (fin) begin
				outs[1] = '{sextet_ascii({b[3:0], 2'b00}), 1'b0};
				outs[2] = '{CHAR_PAD, 1'b1};
				n = 3;
			end else begin
				enc_carry = b[3:0];
				enc_phase = PH_THIRD;
				n = 1;
			end
		end
		PH_THIRD: begin
			outs[0] = '{sextet_ascii({enc_carry, b[7:6]}), 1'b0};
			outs[1] = '{sextet_ascii(b[5:0]), fin};
			enc_carry = 4'h0;
			enc_phase = PH_FIRST;
			n = 2;
		end
		default: begin
			outs[0] = '{sextet_ascii(b[7:2]), 1'b0};
			if (fin) begin
				outs[1] = '{sextet_ascii({b[1:0], 4'h0}), 1'b0};
				outs[2] = '{CHAR_PAD, 1'b0};
				outs[3] = '{CHAR_PAD, 1'b1};
				n = 4;
			end else begin
				enc_carry = {2'b00, b[1:0]};
				enc_phase = PH_SECOND;
				n = 1;
			end
		end
		endcase
		if (fin) begin
			enc_carry = 4'h0;
			enc_phase = PH_FIRST;
		end
		return n;
	endfunction

	task automatic flag_error(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("tb: mismatch at cycle %0d: %s", cycles, msg);
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		b64_char_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			chars_seen++;
			if (expected_chars.size() == 0) begin
				flag_error($sformatf("unexpected char %h last %b", m_axis_tdata, m_axis_tlast));
			end else begin
				want = expected_chars.pop_front();
				if (m_axis_tdata !== {1'b0, want.ch})
					flag_error($sformatf("char exp %h got %h", {1'b0, want.ch}, m_axis_tdata));
				if (m_axis_tlast !== want.fin)
					flag_error($sformatf("tlast exp %b got %b", want.fin, m_axis_tlast));
			end
		end
	end

	// n_typed of zero means the expected characters come from the predictor
	task automatic send_byte(input logic [7:0] d, input logic fin, input int n_typed,
		input logic [31:0] typed);
		b64_char_t outs [4];
		int n;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		s_axis_tlast <= fin;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		n = encode_byte(d, fin, outs);
		if (n_typed != 0) begin
			n = n_typed;
			for (int k = 0; k < n; k++)
				outs[k] = '{typed[(n - 1 - k) * 8 +: 7], fin && (k == n - 1)};
		end
		for (int k = 0; k < n; k++)
			expected_chars.push_back(outs[k]);
		bytes_sent++;
		if (fin)
			messages++;
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_alphabet(input logic url);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= url;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		alpha_url = url;
		cfg_writes++;
	endtask

	task automatic run_messages(input int n_bytes);
		int sent;
		int len;
		logic [7:0] b;
		sent = 0;
		while (sent < n_bytes) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(24, 8) : $urandom_range(7, 1);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(7) == 0)
					b = $urandom_range(1) ? 8'hFF : 8'h00;
				else
					b = 8'($urandom_range(255));
				send_byte(b, i == len - 1, 0, 32'h0);
			end
			sent += len;
		end
	endtask

	task automatic run_phase(input logic url, input int idle, input int stall, input int n);
		set_alphabet(url);
		send_idle_pct = idle;
		stall_pct = stall;
		run_messages(n);
		wait_drained();
	endtask

	initial begin
		#1 arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++) begin
			if (DIRECTED[i].url != alpha_url)
				set_alphabet(DIRECTED[i].url);
			send_byte(DIRECTED[i].data, DIRECTED[i].last, DIRECTED[i].n_typed,
				DIRECTED[i].text);
		end
		wait_drained();

		run_phase(1'b1, 0, 0, 30);
		run_phase(1'b0, 67, 0, 30);
		run_phase(1'b1, 0, 67, 30);
		run_phase(1'b0, 30, 30, 30);

		// output held off while bytes keep coming, then a full drain
		set_alphabet(1'b1);
		send_idle_pct = 0;
		stall_pct = 0;
		hold_left = 150;
		run_messages(25);
		wait_drained();

		repeat (20) @(posedge clk);
		if (expected_chars.size() != 0)
			flag_error($sformatf("%0d characters never arrived", expected_chars.size()));
		$display("tb: %0d bytes in %0d messages encoded, %0d characters checked",
			bytes_sent, messages, chars_seen);
		$display("tb: %0d alphabet writes, idle and stall phases plus a long output hold",
			cfg_writes);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: %0d mismatches", mismatches);
			$display("tb: failure");
		end
		$finish;
	end

endmodule
